@@ design/hsa_pkg.sv @@
// Shared types, constants and helpers for the handle slot allocator.
// No dependencies; imported by every module of the block.
package hsa_pkg;

    // Table geometry (SLOTS is a power of two, at most 2^24)
    localparam int SLOTS        = 256;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int CONTEXT_BITS = 16;
    localparam int HANDLE_BITS  = 24;
    localparam int HARBOR_BITS  = 8;

    typedef logic [SLOT_BITS-1:0]    t_slot;
    typedef logic [HANDLE_BITS-1:0]  t_handle;
    typedef logic [CONTEXT_BITS-1:0] t_ctx;
    typedef logic [HARBOR_BITS-1:0]  t_harbor;

    // Request codes
    typedef logic [1:0] t_req;
    localparam t_req REQ_REGISTER = 2'd0;
    localparam t_req REQ_RETIRE   = 2'd1;
    localparam t_req REQ_GRAB     = 2'd2;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    // One stored table entry
    typedef struct packed {
        t_handle handle;
        t_ctx    ctx;
    } t_entry;

    // Write request into the slot memory
    typedef struct packed {
        logic   we;
        t_slot  addr;
        t_entry data;
    } t_ram_wr;

    // One result as delivered on the output channel
    typedef struct packed {
        t_status     status;
        logic [31:0] handle;
        logic [15:0] ctx;
    } t_result;

    // Stored context id to the 16-bit output field
    function automatic logic [15:0] ctx_to_out(input t_ctx c);
        logic [31:0] t;
        t = 32'(c);
        return t[15:0];
    endfunction

endpackage

@@ design/handle_slot_allocator_core.sv @@
// Handle slot allocator: 256-entry table mapping 24-bit handles to context ids.
// Register request: occupied slots are probed from the next index, one per cycle,
// until a free one is taken; a full table answers once all 256 slots are probed.
// Retire and grab: one memory read. One request in flight; the output register lets
// the next request in meanwhile. Synchronous active-low reset empties the table
// at once, sets next index to 1 and harbor id to 0.
module handle_slot_allocator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  hsa_pkg::t_req         i_req_type,
    input  logic [31:0]           i_handle_in,
    input  logic [15:0]           i_context_id,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output hsa_pkg::t_status      o_status,
    output logic [31:0]           o_handle_out,
    output logic [15:0]           o_context_out
);
    import hsa_pkg::*;

    t_harbor  r_harbor;
    logic     r_out_valid;
    t_result  r_out;

    logic     in_ready;
    logic     res_valid;
    logic     res_take;
    t_result  res;
    t_ram_wr  ram_wr;
    t_slot    ram_raddr;
    t_entry   ram_rd;

    // harbor id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harbor <= '0;
        end else if (i_cfg_wr_en) begin
            r_harbor <= i_cfg_wr_data;
        end
    end

    hsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (i_req_type),
        .i_handle_in  (i_handle_in),
        .i_context_id (i_context_id),
        .i_harbor     (r_harbor),
        .o_ram_wr     (ram_wr),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rd     (ram_rd),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    hsa_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_raddr   (ram_raddr),
        .o_rd_data (ram_rd)
    );

    // output register: load when empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_in_stall    = !in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_handle_out  = r_out.handle;
    assign o_context_out = r_out.ctx;

endmodule

@@ design/hsa_slot_ram.sv @@
// Slot memory holding the handle and context id of every table entry.
// Depends on hsa_pkg. One write port, one registered read port.
module hsa_slot_ram (
    input  logic             i_clk,
    input  hsa_pkg::t_ram_wr i_wr,
    input  hsa_pkg::t_slot   i_raddr,
    output hsa_pkg::t_entry  o_rd_data
);
    import hsa_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read, every cycle
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_raddr];
    end

    assign o_rd_data = r_rd;

endmodule

@@ design/hsa_ctrl.sv @@
// Request sequencer: probe loop for register, lookup for retire and grab.
// Depends on hsa_pkg; drives the slot memory and holds the slot valid bits.
module hsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hsa_pkg::t_req    i_req_type,
    input  logic [31:0]      i_handle_in,
    input  logic [15:0]      i_context_id,
    input  hsa_pkg::t_harbor i_harbor,
    output hsa_pkg::t_ram_wr o_ram_wr,
    output hsa_pkg::t_slot   o_ram_raddr,
    input  hsa_pkg::t_entry  i_ram_rd,
    output logic             o_res_valid,
    input  logic             i_res_take,
    output hsa_pkg::t_result o_res
);
    import hsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_LOOK  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam t_slot LAST_PROBE = SLOT_BITS'(SLOTS - 1);

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [31:0]     r_hin, n_hin;
    t_ctx            r_ctx, n_ctx;
    t_handle         r_probe_h, n_probe_h;
    t_slot           r_count, n_count;
    t_handle         r_next_index, n_next_index;
    logic [SLOTS-1:0] r_used, n_used;
    t_result         r_res, n_res;

    t_slot probe_slot;
    t_slot look_slot;
    logic  hit;

    assign probe_slot  = r_probe_h[SLOT_BITS-1:0];
    assign look_slot   = r_hin[SLOT_BITS-1:0];
    assign o_ram_raddr = i_handle_in[SLOT_BITS-1:0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    // lookup hit: valid slot, matching handle and harbor byte
    assign hit = r_used[look_slot] && (i_ram_rd.handle == r_hin[HANDLE_BITS-1:0])
                 && (r_hin[31:24] == i_harbor);

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_hin        = r_hin;
        n_ctx        = r_ctx;
        n_probe_h    = r_probe_h;
        n_count      = r_count;
        n_next_index = r_next_index;
        n_used       = r_used;
        n_res        = r_res;
        o_ram_wr.we          = 1'b0;
        o_ram_wr.addr        = probe_slot;
        o_ram_wr.data.handle = r_probe_h;
        o_ram_wr.data.ctx    = r_ctx;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_req_type;
                    n_hin     = i_handle_in;
                    n_ctx     = t_ctx'(i_context_id);
                    n_probe_h = r_next_index;
                    n_count   = '0;
                    if (i_req_type == REQ_REGISTER) begin
                        n_state = S_PROBE;
                    end else if (i_req_type == REQ_RETIRE || i_req_type == REQ_GRAB) begin
                        n_state = S_LOOK;
                    end else begin
                        n_res.status = ST_NOT_FOUND;
                        n_res.handle = '0;
                        n_res.ctx    = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            // one slot tested per cycle
            S_PROBE: begin
                if (!r_used[probe_slot]) begin
                    o_ram_wr.we          = 1'b1;
                    n_used[probe_slot]   = 1'b1;
                    n_next_index         = r_probe_h + 1'b1;
                    n_res.status         = ST_OK;
                    n_res.handle         = {i_harbor, r_probe_h};
                    n_res.ctx            = '0;
                    n_state              = S_DONE;
                end else if (r_count == LAST_PROBE) begin
                    n_res.status = ST_FULL;
                    n_res.handle = '0;
                    n_res.ctx    = '0;
                    n_state      = S_DONE;
                end else begin
                    n_probe_h = r_probe_h + 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            // memory data for the request's slot is present now
            S_LOOK: begin
                if (hit) begin
                    if (r_req == REQ_RETIRE) begin
                        n_used[look_slot] = 1'b0;
                    end
                    n_res.status = ST_OK;
                    n_res.handle = r_hin;
                    n_res.ctx    = ctx_to_out(i_ram_rd.ctx);
                end else begin
                    n_res.status = ST_NOT_FOUND;
                    n_res.handle = '0;
                    n_res.ctx    = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_index <= HANDLE_BITS'(1);
            r_used       <= '0;
        end else begin
            r_state      <= n_state;
            r_next_index <= n_next_index;
            r_used       <= n_used;
        end
    end

    // request payload and probe registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_hin     <= n_hin;
        r_ctx     <= n_ctx;
        r_probe_h <= n_probe_h;
        r_count   <= n_count;
        r_res     <= n_res;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for handle_slot_allocator_core: directed, table-full, hold-off and random phases.
// Predicts every result from its own copy of the handle table. Depends on hsa_pkg and the core.
module tb_top;
    import hsa_pkg::*;

    localparam t_req REQ_UNUSED       = 2'd3;
    localparam int   LIMIT_CYCLES     = 3_000_000;
    localparam int   HOLD_CYCLES      = 400;
    localparam int   RANDOM_PER_PHASE = 150;
    localparam int   END_WAIT         = 300;

    // Clock, reset and block inputs, all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'd0;
    logic        i_in_valid    = 1'b0;
    t_req        i_req_type    = REQ_REGISTER;
    logic [31:0] i_handle_in   = 32'd0;
    logic [15:0] i_context_id  = 16'd0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_status     o_status;
    logic [31:0] o_handle_out;
    logic [15:0] o_context_out;

    // Predicted table state
    bit          slot_used [SLOTS];
    t_handle     slot_handle [SLOTS];
    t_ctx        slot_ctx [SLOTS];
    t_handle     next_handle = 24'd1;
    t_harbor     harbor      = 8'd0;
    int          used_count  = 0;

    t_result     pending_results [$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_seq      = 0;
    int          cycle_count   = 0;

    handle_slot_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_handle_in   (i_handle_in),
        .i_context_id  (i_context_id),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_handle_out  (o_handle_out),
        .o_context_out (o_context_out)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Apply one request to the predicted table and return its result
    function automatic t_result table_apply(t_req r, logic [31:0] hin, logic [15:0] ctx);
        t_result res;
        t_handle probe;
        t_slot   s;
        bit      placed;
        res.status = ST_NOT_FOUND;
        res.handle = '0;
        res.ctx    = '0;
        placed     = 1'b0;
        case (r)
            REQ_REGISTER: begin
                res.status = ST_FULL;
                for (int i = 0; i < SLOTS; i++) begin
                    probe = next_handle + t_handle'(i);
                    s     = probe[SLOT_BITS-1:0];
                    if (!placed && !slot_used[s]) begin
                        placed         = 1'b1;
                        slot_used[s]   = 1'b1;
                        slot_handle[s] = probe;
                        slot_ctx[s]    = ctx;
                        next_handle    = probe + 24'd1;
                        used_count++;
                        res.status = ST_OK;
                        res.handle = {harbor, probe};
                    end
                end
            end
            REQ_RETIRE, REQ_GRAB: begin
                s = hin[SLOT_BITS-1:0];
                if (slot_used[s] && slot_handle[s] == hin[23:0] && hin[31:24] == harbor) begin
                    res.status = ST_OK;
                    res.handle = hin;
                    res.ctx    = slot_ctx[s];
                    if (r == REQ_RETIRE) begin
                        slot_used[s] = 1'b0;
                        used_count--;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Random occupied slot, or -1 when the table is empty
    function automatic int pick_live_slot();
        int start;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
            if (slot_used[(start + k) % SLOTS]) return (start + k) % SLOTS;
        return -1;
    endfunction

    function automatic logic [31:0] live_handle(int s);
        return {harbor, slot_handle[s]};
    endfunction

    // Offer one request and hold it until taken; predict at acceptance
    task automatic send_request(t_req r, logic [31:0] h, logic [15:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= r;
        i_handle_in  <= h;
        i_context_id <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(table_apply(r, h, c));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Harbor write; only called with nothing in flight
    task automatic set_harbor(t_harbor hb);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= hb;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        harbor = hb;
    endtask

    // Mostly well-formed traffic on live handles, with some noise
    task automatic random_request();
        int          roll;
        int          s;
        logic [31:0] h;
        roll = $urandom_range(0, 99);
        s    = pick_live_slot();
        // keep the table from sitting full for long
        if (roll < 40 && used_count > 200) roll = 70;
        if (s < 0 && roll >= 40 && roll < 95) roll = 0;
        if (roll < 40) begin
            send_request(REQ_REGISTER, $urandom, 16'($urandom));
        end else if (roll < 65) begin
            send_request(REQ_GRAB, live_handle(s), 16'($urandom));
        end else if (roll < 85) begin
            send_request(REQ_RETIRE, live_handle(s), 16'($urandom));
        end else if (roll < 90) begin
            // right low bits, wrong harbor byte
            h = live_handle(s) ^ {8'($urandom_range(1, 255)), 24'd0};
            send_request(roll[0] ? REQ_GRAB : REQ_RETIRE, h, 16'($urandom));
        end else if (roll < 95) begin
            // same slot, different stored handle; or anything at all
            if (roll[0])
                h = {harbor, slot_handle[s] + t_handle'(SLOTS * $urandom_range(1, 1000))};
            else
                h = $urandom;
            send_request(roll[1] ? REQ_GRAB : REQ_RETIRE, h, 16'($urandom));
        end else begin
            send_request(REQ_UNUSED, $urandom, 16'($urandom));
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin : drive_out_stall
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", o_handle_out, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_handle_out !== want.handle)
                    report_mismatch("handle_out", o_handle_out, want.handle);
                if (o_context_out !== want.ctx)
                    report_mismatch("context_out", 32'(o_context_out), 32'(want.ctx));
            end
        end
    end

    // Hand-picked requests: context extremes, hits, misses, harbor change
    task automatic test_directed();
        send_request(REQ_GRAB, 32'h0000_0001, 16'h0000);     // empty table
        send_request(REQ_REGISTER, 32'h0000_0000, 16'h0000);
        send_request(REQ_REGISTER, 32'hffff_ffff, 16'hffff);
        send_request(REQ_GRAB, 32'h0000_0001, 16'h0000);
        send_request(REQ_GRAB, 32'h0000_0002, 16'hffff);
        send_request(REQ_GRAB, 32'h0100_0002, 16'h0000);     // harbor mismatch
        send_request(REQ_RETIRE, 32'h0000_0001, 16'h0000);
        send_request(REQ_GRAB, 32'h0000_0001, 16'h0000);     // retired
        send_request(REQ_RETIRE, 32'h0000_0001, 16'h0000);
        send_request(REQ_UNUSED, 32'h0000_0002, 16'hffff);   // unused code
        send_request(REQ_GRAB, 32'hffff_ffff, 16'hffff);
        send_request(REQ_REGISTER, 32'h0000_0000, 16'ha5a5);
        send_request(REQ_RETIRE, 32'h0000_0102, 16'h0000);   // slot taken, other handle
        send_request(REQ_REGISTER, 32'h0000_0000, 16'h5a5a); // slot 1 is free again; probe starts at 4
        wait_all_results();
        set_harbor(8'hff);
        send_request(REQ_REGISTER, 32'h0000_0000, 16'h1234);
        send_request(REQ_GRAB, 32'hff00_0005, 16'h0000);
        send_request(REQ_GRAB, 32'h0000_0005, 16'h0000);     // old harbor
        send_request(REQ_RETIRE, 32'hff00_0002, 16'h0000);
        send_request(REQ_UNUSED, 32'hffff_ffff, 16'hffff);
        wait_all_results();
    endtask

    // Fill every slot, overflow, free one and refill, then empty the table
    task automatic test_table_full();
        int s;
        send_idle_pct = 12;
        stall_pct     = 12;
        while (used_count < SLOTS) send_request(REQ_REGISTER, $urandom, 16'($urandom));
        send_request(REQ_REGISTER, 32'hffff_ffff, 16'hffff);
        send_request(REQ_GRAB, live_handle(pick_live_slot()), 16'h0000);
        send_request(REQ_RETIRE, live_handle(pick_live_slot()), 16'h0000);
        send_request(REQ_REGISTER, $urandom, 16'($urandom));   // long probe to the hole
        send_request(REQ_REGISTER, $urandom, 16'($urandom));   // full again
        for (s = 0; s < SLOTS; s++)
            if (slot_used[s]) send_request(REQ_RETIRE, live_handle(s), 16'($urandom));
        wait_all_results();
    endtask

    // Receiver holds off while requests keep coming, so the input backs up
    task automatic test_receiver_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int n = 0; n < 40; n++) send_request(REQ_REGISTER, $urandom, 16'($urandom));
        hold_seq++;
        for (int n = 0; n < 24; n++) random_request();
        wait_all_results();
    endtask

    // One random phase at a given idling mix and harbor
    task automatic test_random_phase(int idle_p, int stall_p, t_harbor hb);
        wait_all_results();
        set_harbor(hb);
        send_idle_pct = idle_p;
        stall_pct     = stall_p;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            random_request();
            // now and then let everything drain before going on
            if ($urandom_range(0, 49) == 0) wait_all_results();
        end
        wait_all_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_full();
        test_receiver_hold();
        test_random_phase(0, 0, 8'h00);
        test_random_phase(59, 0, 8'($urandom));
        test_random_phase(0, 59, 8'hff);
        test_random_phase(12, 12, 8'h01);
        send_idle_pct = 0;
        stall_pct     = 0;
        wait_all_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
